// ===== rtl/suffix_array_bwt_builder_defines.svh =====
// Assertion macros for the suffix array and BWT builder RTL.
`ifndef SUFFIX_ARRAY_BWT_BUILDER_DEFINES_SVH
`define SUFFIX_ARRAY_BWT_BUILDER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SABB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SABB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sabb_pkg.sv =====
`default_nettype none

package sabb_pkg;

    localparam int MAX_LEN = 4096;
    localparam int AW      = 12;   // text position width
    localparam int NW      = 13;   // length, count and key width
    localparam int SYM_W   = 7;

    localparam logic [SYM_W-1:0] TERMINATOR = 7'd36;
    localparam logic [NW-1:0]    SYM_SPAN   = 13'd128;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_BUILT  = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_ERROR  = 2'd3;

    typedef enum logic [25:0] {
        S_IDLE    = 26'b1 << 0,
        S_RD_T0   = 26'b1 << 1,
        S_RD_T1   = 26'b1 << 2,
        S_RD_T2   = 26'b1 << 3,
        S_TERM    = 26'b1 << 4,
        S_INIT_RD = 26'b1 << 5,
        S_INIT_WR = 26'b1 << 6,
        S_CLR     = 26'b1 << 7,
        S_CNT_SRC = 26'b1 << 8,
        S_CNT_KEY = 26'b1 << 9,
        S_CNT_BKT = 26'b1 << 10,
        S_CNT_WR  = 26'b1 << 11,
        S_PFX_RD  = 26'b1 << 12,
        S_PFX_WR  = 26'b1 << 13,
        S_SCT_SRC = 26'b1 << 14,
        S_SCT_KEY = 26'b1 << 15,
        S_SCT_BKT = 26'b1 << 16,
        S_SCT_WR  = 26'b1 << 17,
        S_REN_SRC = 26'b1 << 18,
        S_REN_R0  = 26'b1 << 19,
        S_REN_R1  = 26'b1 << 20,
        S_REN_WR  = 26'b1 << 21,
        S_CPY_RD  = 26'b1 << 22,
        S_CPY_WR  = 26'b1 << 23,
        S_FIN     = 26'b1 << 24,
        S_RESULT  = 26'b1 << 25
    } t_state;

    typedef struct packed {
        logic             operation;
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic [AW-1:0]    rank;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [AW-1:0]    suffix_start;
        logic [SYM_W-1:0] first_symbol;
        logic [SYM_W-1:0] bwt_symbol;
        logic [NW-1:0]    text_length;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        t_state state;
        logic   accept;
        logic   pass_first;   // 0: sort by second key, 1: sort by first key
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic read_ok;
        logic idx_last;
        logic clr_last;
        logic idx_zero;
        logic single;
        logic round_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/sabb_ram.sv =====
`default_nettype none

module sabb_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sabb_ctrl.sv =====
`default_nettype none

module sabb_ctrl
    import sabb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_in   i_in_data,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

`include "suffix_array_bwt_builder_defines.svh"

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   accept;

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    assign o_cmd.state      = r_state;
    assign o_cmd.accept     = accept;
    assign o_cmd.pass_first = r_pass;

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_data.operation == OP_LOAD) begin
                        n_state = i_in_data.last ? S_TERM : S_RESULT;
                    end else begin
                        n_state = i_stat.read_ok ? S_RD_T0 : S_RESULT;
                    end
                end
            end
            S_RD_T0:   n_state = S_RD_T1;
            S_RD_T1:   n_state = S_RD_T2;
            S_RD_T2:   n_state = S_RESULT;
            S_TERM:    n_state = S_INIT_RD;
            S_INIT_RD: n_state = S_INIT_WR;
            S_INIT_WR: begin
                n_pass = 1'b0;
                if (i_stat.idx_last) begin
                    n_state = i_stat.single ? S_FIN : S_CLR;
                end else begin
                    n_state = S_INIT_RD;
                end
            end
            S_CLR:     n_state = i_stat.clr_last ? S_CNT_SRC : S_CLR;
            S_CNT_SRC: n_state = S_CNT_KEY;
            S_CNT_KEY: n_state = S_CNT_BKT;
            S_CNT_BKT: n_state = S_CNT_WR;
            S_CNT_WR:  n_state = i_stat.idx_last ? S_PFX_RD : S_CNT_SRC;
            S_PFX_RD:  n_state = S_PFX_WR;
            S_PFX_WR:  n_state = i_stat.clr_last ? S_SCT_SRC : S_PFX_RD;
            S_SCT_SRC: n_state = S_SCT_KEY;
            S_SCT_KEY: n_state = S_SCT_BKT;
            S_SCT_BKT: n_state = S_SCT_WR;
            S_SCT_WR: begin
                if (!i_stat.idx_zero) begin
                    n_state = S_SCT_SRC;
                end else if (!r_pass) begin
                    n_pass  = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_state = S_REN_SRC;
                end
            end
            S_REN_SRC: n_state = S_REN_R0;
            S_REN_R0:  n_state = S_REN_R1;
            S_REN_R1:  n_state = S_REN_WR;
            S_REN_WR:  n_state = i_stat.idx_last ? S_CPY_RD : S_REN_SRC;
            S_CPY_RD:  n_state = S_CPY_WR;
            S_CPY_WR: begin
                if (!i_stat.idx_last) begin
                    n_state = S_CPY_RD;
                end else if (i_stat.round_done) begin
                    n_state = S_FIN;
                end else begin
                    n_pass  = 1'b0;
                    n_state = S_CLR;
                end
            end
            S_FIN:     n_state = S_RESULT;
            S_RESULT:  n_state = i_stat.out_free ? S_IDLE : S_RESULT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    `SABB_ASSERT_NEXT(a_last_builds,
        accept && (i_in_data.operation == OP_LOAD) && i_in_data.last,
        r_state == S_TERM, "last symbol did not start construction")
    `SABB_ASSERT_NEXT(a_result_leaves,
        (r_state == S_RESULT) && i_stat.out_free,
        r_state == S_IDLE, "result stage did not return to idle")
    `SABB_ASSERT_NOW(a_renumber_after_both,
        r_state == S_REN_SRC, r_pass, "renumbering began before the first-key sort")

endmodule

`default_nettype wire

// ===== rtl/sabb_dpath.sv =====
`default_nettype none

module sabb_dpath
    import sabb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_in   i_in_data,
    input  wire t_cmd  i_cmd,
    input  wire logic  i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output t_out       o_out_data
);

    localparam int BW = NW;   // bucket address width, buckets 0..MAX_LEN

    // Memory ports.
    logic             txt_we;
    logic [AW-1:0]    txt_waddr, txt_raddr;
    logic [SYM_W-1:0] txt_wdata, txt_rd;
    logic             sa_we;
    logic [AW-1:0]    sa_waddr, sa_raddr, sa_wdata, sa_rd;
    logic             sa2_we;
    logic [AW-1:0]    sa2_waddr, sa2_wdata, sa2_rd;
    logic             rk_we;
    logic [AW-1:0]    rk_waddr, rk_raddr, rk_wdata, rk_rd;
    logic             rn_we;
    logic [AW-1:0]    rn_wdata, rn_rd;
    logic             bk_we;
    logic [BW-1:0]    bk_waddr, bk_raddr;
    logic [NW-1:0]    bk_wdata, bk_rd;

    // Registers.
    logic [NW-1:0]    r_n;
    logic             r_built;
    logic [NW-1:0]    r_k;
    logic [NW-1:0]    r_i;
    logic [NW-1:0]    r_acc;
    logic [AW-1:0]    r_p;
    logic             r_in_rng;
    logic [NW-1:0]    r_key;
    logic [AW-1:0]    r_ra, r_prev_ra, r_prev_new;
    logic [NW-1:0]    r_prev_k2;
    logic [1:0]       r_status;
    logic [AW-1:0]    r_start;
    logic [SYM_W-1:0] r_first, r_bwt;
    logic             r_out_valid;
    t_out             r_out;

    logic [NW-1:0]    n_eff, span_m1, key, k2, bk_dec;
    logic [NW:0]      pk_src, pk_p;
    logic [AW-1:0]    src_rd, new_rank, prev_pos;
    logic             load_ok, read_ok, same, is_load;

    assign is_load = (i_in_data.operation == OP_LOAD);
    assign n_eff   = r_built ? '0 : r_n;
    assign load_ok = (i_in_data.symbol > TERMINATOR) && (n_eff < NW'(MAX_LEN - 1));
    assign read_ok = r_built && ({1'b0, i_in_data.rank} < r_n);
    assign span_m1 = (r_n > SYM_SPAN) ? r_n : SYM_SPAN;

    assign src_rd = i_cmd.pass_first ? sa2_rd : sa_rd;
    assign pk_src = {2'b00, src_rd} + {1'b0, r_k};
    assign pk_p   = {2'b00, r_p} + {1'b0, r_k};
    assign key    = i_cmd.pass_first ? {1'b0, rk_rd}
                  : (r_in_rng ? ({1'b0, rk_rd} + NW'(1)) : '0);
    assign k2     = r_in_rng ? ({1'b0, rk_rd} + NW'(1)) : '0;
    assign bk_dec = bk_rd - NW'(1);
    assign same   = (r_i != '0) && (r_ra == r_prev_ra) && (k2 == r_prev_k2);
    assign new_rank = (r_i == '0) ? '0 : (r_prev_new + (same ? AW'(0) : AW'(1)));
    assign prev_pos = (r_start == '0) ? AW'(r_n - NW'(1)) : (r_start - AW'(1));

    assign o_stat.read_ok    = read_ok;
    assign o_stat.idx_last   = (r_i == r_n - NW'(1));
    assign o_stat.clr_last   = (r_i == span_m1);
    assign o_stat.idx_zero   = (r_i == '0);
    assign o_stat.single     = (r_n == NW'(1));
    assign o_stat.round_done = ({1'b0, r_prev_new} == r_n - NW'(1))
                             || ({r_k, 1'b0} >= {1'b0, r_n});
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Memory address and write selection.
    always_comb begin
        txt_we    = 1'b0;
        txt_waddr = n_eff[AW-1:0];
        txt_wdata = i_in_data.symbol;
        txt_raddr = r_i[AW-1:0];
        sa_we     = 1'b0;
        sa_waddr  = r_i[AW-1:0];
        sa_wdata  = r_i[AW-1:0];
        sa_raddr  = r_i[AW-1:0];
        sa2_we    = 1'b0;
        sa2_waddr = bk_dec[AW-1:0];
        sa2_wdata = r_p;
        rk_we     = 1'b0;
        rk_waddr  = r_i[AW-1:0];
        rk_wdata  = {{(AW-SYM_W){1'b0}}, txt_rd};
        rk_raddr  = r_p;
        rn_we     = 1'b0;
        rn_wdata  = new_rank;
        bk_we     = 1'b0;
        bk_waddr  = r_key;
        bk_wdata  = '0;
        bk_raddr  = r_i;
        case (i_cmd.state)
            S_IDLE: begin
                sa_raddr = i_in_data.rank;
                txt_we   = i_cmd.accept && is_load && load_ok;
            end
            S_RD_T0: txt_raddr = sa_rd;
            S_RD_T1: txt_raddr = prev_pos;
            S_TERM: begin
                txt_we    = 1'b1;
                txt_waddr = r_n[AW-1:0];
                txt_wdata = TERMINATOR;
            end
            S_INIT_WR: begin
                sa_we = 1'b1;
                rk_we = 1'b1;
            end
            S_CLR: begin
                bk_we    = 1'b1;
                bk_waddr = r_i;
            end
            S_CNT_KEY, S_SCT_KEY: begin
                rk_raddr = i_cmd.pass_first ? src_rd : pk_src[AW-1:0];
            end
            S_CNT_BKT, S_SCT_BKT: bk_raddr = key;
            S_CNT_WR: begin
                bk_we    = 1'b1;
                bk_wdata = bk_rd + NW'(1);
            end
            S_PFX_WR: begin
                bk_we    = 1'b1;
                bk_waddr = r_i;
                bk_wdata = r_acc + bk_rd;
            end
            S_SCT_WR: begin
                bk_we    = 1'b1;
                bk_wdata = bk_dec;
                if (i_cmd.pass_first) begin
                    sa_we    = 1'b1;
                    sa_waddr = bk_dec[AW-1:0];
                    sa_wdata = r_p;
                end else begin
                    sa2_we = 1'b1;
                end
            end
            S_REN_R0: rk_raddr = sa_rd;
            S_REN_R1: rk_raddr = pk_p[AW-1:0];
            S_REN_WR: rn_we = 1'b1;
            S_CPY_WR: begin
                rk_we    = 1'b1;
                rk_wdata = rn_rd;
            end
            default: begin
            end
        endcase
    end

    // Control state: length, build flag and result slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.state == S_RESULT && o_stat.out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.state)
                S_IDLE: begin
                    if (i_cmd.accept && is_load) begin
                        r_built <= 1'b0;
                        r_n     <= n_eff + (load_ok ? NW'(1) : NW'(0));
                    end
                end
                S_TERM: r_n     <= r_n + NW'(1);
                S_FIN:  r_built <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.state == S_RESULT && o_stat.out_free) begin
            r_out.status       <= r_status;
            r_out.suffix_start <= r_start;
            r_out.first_symbol <= r_first;
            r_out.bwt_symbol   <= r_bwt;
            r_out.text_length  <= r_n;
        end
        case (i_cmd.state)
            S_IDLE: begin
                r_start <= '0;
                r_first <= '0;
                r_bwt   <= '0;
                if (is_load) begin
                    if (!load_ok) begin
                        r_status <= ST_ERROR;
                    end else begin
                        r_status <= i_in_data.last ? ST_BUILT : ST_LOADED;
                    end
                end else begin
                    r_status <= read_ok ? ST_READ : ST_ERROR;
                end
            end
            S_RD_T0: r_start <= sa_rd;
            S_RD_T1: r_first <= txt_rd;
            S_RD_T2: r_bwt   <= txt_rd;
            S_TERM: begin
                r_k <= NW'(1);
                r_i <= '0;
            end
            S_INIT_WR, S_CNT_WR, S_REN_WR: begin
                r_i   <= o_stat.idx_last ? '0 : (r_i + NW'(1));
                r_acc <= '0;
            end
            S_CLR: r_i <= o_stat.clr_last ? '0 : (r_i + NW'(1));
            S_CNT_KEY, S_SCT_KEY: begin
                r_p      <= src_rd;
                r_in_rng <= (pk_src < {1'b0, r_n});
            end
            S_CNT_BKT, S_SCT_BKT: r_key <= key;
            S_PFX_WR: begin
                r_acc <= r_acc + bk_rd;
                r_i   <= o_stat.clr_last ? (r_n - NW'(1)) : (r_i + NW'(1));
            end
            S_SCT_WR: r_i <= o_stat.idx_zero ? '0 : (r_i - NW'(1));
            S_REN_R0: r_p <= sa_rd;
            S_REN_R1: begin
                r_ra     <= rk_rd;
                r_in_rng <= (pk_p < {1'b0, r_n});
            end
            S_CPY_WR: begin
                r_i <= o_stat.idx_last ? '0 : (r_i + NW'(1));
                if (o_stat.idx_last) begin
                    r_k <= {r_k[NW-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.state == S_REN_WR) begin
            r_prev_ra  <= r_ra;
            r_prev_k2  <= k2;
            r_prev_new <= new_rank;
        end
    end

    sabb_ram #(.W(SYM_W), .D(MAX_LEN)) u_text (
        .i_clk(i_clk), .i_we(txt_we), .i_waddr(txt_waddr), .i_wdata(txt_wdata),
        .i_raddr(txt_raddr), .o_rdata(txt_rd)
    );

    sabb_ram #(.W(AW), .D(MAX_LEN)) u_order (
        .i_clk(i_clk), .i_we(sa_we), .i_waddr(sa_waddr), .i_wdata(sa_wdata),
        .i_raddr(sa_raddr), .o_rdata(sa_rd)
    );

    sabb_ram #(.W(AW), .D(MAX_LEN)) u_order_nx (
        .i_clk(i_clk), .i_we(sa2_we), .i_waddr(sa2_waddr), .i_wdata(sa2_wdata),
        .i_raddr(r_i[AW-1:0]), .o_rdata(sa2_rd)
    );

    sabb_ram #(.W(AW), .D(MAX_LEN)) u_rank (
        .i_clk(i_clk), .i_we(rk_we), .i_waddr(rk_waddr), .i_wdata(rk_wdata),
        .i_raddr(rk_raddr), .o_rdata(rk_rd)
    );

    sabb_ram #(.W(AW), .D(MAX_LEN)) u_rank_nx (
        .i_clk(i_clk), .i_we(rn_we), .i_waddr(r_p), .i_wdata(rn_wdata),
        .i_raddr(r_i[AW-1:0]), .o_rdata(rn_rd)
    );

    sabb_ram #(.W(NW), .D(MAX_LEN + 1)) u_bucket (
        .i_clk(i_clk), .i_we(bk_we), .i_waddr(bk_waddr), .i_wdata(bk_wdata),
        .i_raddr(bk_raddr), .o_rdata(bk_rd)
    );

endmodule

`default_nettype wire

// ===== rtl/suffix_array_bwt_builder.sv =====
// A load's result passes the result state into the output register; a read first fetches
// the suffix start, first and BWT symbols. A load marked last adds construction: terminator,
// initialization, then at most ceil(log2(n)) doubling rounds, n the length with terminator.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (synchronous, active low) empties the text, clears the built flag and the result.
`default_nettype none

// Suffix array and Burrows-Wheeler transform builder.
//
// The controller walks the construction one memory access at a time. Every
// memory has one write and one registered read port, so each step of the
// sort issues an address in one state and consumes the data in the next.
// A doubling round is two stable counting sorts (second key, then first
// key), a renumbering pass and a copy of the new ranks. Construction ends
// early when the highest new rank reaches n-1, meaning all ranks differ.
//
// The output side is a single result register, so a result that waits on a
// stalled consumer does not stop the block from finishing the item that
// follows it until that item's own result is ready.
module suffix_array_bwt_builder
    import sabb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    // Command and status between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    sabb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    sabb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sim/suffix_array_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the suffix array builder, keeps its own copy of
// the text and the sorted suffix order, and compares every result transfer
// against the oldest predicted result.
module suffix_array_checker
    import sabb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_stall,
    input  wire t_in  i_in_data,
    input  wire logic i_out_valid,
    input  wire logic i_out_stall,
    input  wire t_out i_out_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked,
    output int        o_builds
);

    logic [SYM_W-1:0] text_mem [MAX_LEN];
    int               sorted_pos [MAX_LEN];
    int               scratch_pos [MAX_LEN];
    int               rank_cur [MAX_LEN];
    int               rank_new [MAX_LEN];
    int               bucket [MAX_LEN + 2];
    int               text_len;
    bit               is_built;
    t_out             expected_results[$];

    function automatic int sort_key(int p, int k, int n, bit by_first);
        if (by_first) begin
            return rank_cur[p];
        end
        return (p + k < n) ? rank_cur[p + k] + 1 : 0;
    endfunction

    // One stable counting sort. The second-key pass moves sorted_pos into
    // scratch_pos, the first-key pass moves it back.
    function automatic void counting_pass(bit by_first, int k, int n, int span);
        int p;
        int key;
        for (int b = 0; b <= span; b++) begin
            bucket[b] = 0;
        end
        for (int i = 0; i < n; i++) begin
            p = by_first ? scratch_pos[i] : sorted_pos[i];
            bucket[sort_key(p, k, n, by_first)]++;
        end
        for (int b = 1; b < span; b++) begin
            bucket[b] += bucket[b - 1];
        end
        for (int i = n - 1; i >= 0; i--) begin
            p = by_first ? scratch_pos[i] : sorted_pos[i];
            key = sort_key(p, k, n, by_first);
            bucket[key]--;
            if (by_first) begin
                sorted_pos[bucket[key]] = p;
            end else begin
                scratch_pos[bucket[key]] = p;
            end
        end
    endfunction

    // Appends the terminator and sorts all suffixes by prefix doubling.
    function automatic void build_suffix_order();
        int n;
        int span;
        int a;
        int b;
        bit same;
        text_mem[text_len] = TERMINATOR;
        text_len++;
        n = text_len;
        for (int i = 0; i < n; i++) begin
            sorted_pos[i] = i;
            rank_cur[i] = text_mem[i];
        end
        span = ((n > 128) ? n : 128) + 1;
        for (int k = 1; k < n; k *= 2) begin
            counting_pass(1'b0, k, n, span);
            counting_pass(1'b1, k, n, span);
            rank_new[sorted_pos[0]] = 0;
            for (int i = 1; i < n; i++) begin
                a = sorted_pos[i];
                b = sorted_pos[i - 1];
                same = rank_cur[a] == rank_cur[b] &&
                       sort_key(a, k, n, 1'b0) == sort_key(b, k, n, 1'b0);
                rank_new[a] = rank_new[b] + (same ? 0 : 1);
            end
            for (int i = 0; i < n; i++) begin
                rank_cur[i] = rank_new[i];
            end
            if (rank_cur[sorted_pos[n - 1]] == n - 1) begin
                break;
            end
        end
        is_built = 1'b1;
        o_builds++;
    endfunction

    function automatic t_out predict_result(t_in it);
        t_out r;
        bit   ok;
        int   start;
        r = '0;
        r.status = ST_ERROR;
        if (it.operation == OP_LOAD) begin
            if (is_built) begin
                is_built = 1'b0;
                text_len = 0;
            end
            ok = it.symbol > TERMINATOR && text_len < MAX_LEN - 1;
            if (ok) begin
                text_mem[text_len] = it.symbol;
                text_len++;
                r.status = ST_LOADED;
            end
            if (it.last) begin
                build_suffix_order();
                if (ok) begin
                    r.status = ST_BUILT;
                end
            end
        end else if (is_built && it.rank < text_len) begin
            start = sorted_pos[it.rank];
            r.suffix_start = start[AW-1:0];
            r.first_symbol = text_mem[start];
            r.bwt_symbol = text_mem[(start == 0) ? text_len - 1 : start - 1];
            r.status = ST_READ;
        end
        r.text_length = text_len[NW-1:0];
        return r;
    endfunction

    // Channels change only at the rising edge, so their values at the
    // falling edge are the ones the next rising edge will act on.
    always @(negedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            text_len = 0;
            is_built = 1'b0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_results.insert(expected_results.size(),
                                        predict_result(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) begin
                        $display("%0t: result transfer with nothing expected", $realtime);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want.status != i_out_data.status ||
                        want.suffix_start != i_out_data.suffix_start ||
                        want.first_symbol != i_out_data.first_symbol ||
                        want.bwt_symbol != i_out_data.bwt_symbol ||
                        want.text_length != i_out_data.text_length) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("%0t: mismatch, expected status %0d start %0d %s",
                                     $realtime, want.status, want.suffix_start, "");
                            $display("    first %0d bwt %0d len %0d", want.first_symbol,
                                     want.bwt_symbol, want.text_length);
                            $display("    got status %0d start %0d first %0d bwt %0d len %0d",
                                     i_out_data.status, i_out_data.suffix_start,
                                     i_out_data.first_symbol, i_out_data.bwt_symbol,
                                     i_out_data.text_length);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_checked = 0;
        o_builds = 0;
        text_len = 0;
        is_built = 1'b0;
    end

endmodule

// ===== sim/suffix_array_bwt_builder_tb.sv =====
`timescale 1ns / 1ps

// Drives load and read items into the suffix array builder with random gaps
// on both channels. All prediction and comparison lives in the checker; this
// module only makes stimulus and gives the verdict.
module suffix_array_bwt_builder_tb;
    import sabb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;

    int errors;
    int pending;
    int checked;
    int builds;
    int items_sent;

    // When burst is set, neither side inserts any idle cycles.
    bit burst;
    // The sender raises this once to make the receiver hold off for a long
    // stretch, so the block fills up and stalls its input.
    bit hold_pending;
    bit hold_done;
    int hold_left;
    int rx_wait;
    bit out_fire;

    suffix_array_bwt_builder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    suffix_array_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_builds    (builds)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // A result transfer takes place at the next rising edge exactly when
    // this holds at the falling edge before it.
    always @(negedge i_clk) begin
        out_fire <= out_valid && !out_stall;
    end

    // Receiver: after each result transfer it draws a number of stall
    // cycles for the next one. The long hold-off is counted here as well.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            rx_wait = 0;
        end else if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            out_stall <= 1'b1;
        end else begin
            if (out_fire) begin
                rx_wait = burst ? 0 : $urandom_range(0, 15);
            end
            if (rx_wait > 0) begin
                out_stall <= 1'b1;
                rx_wait--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a rising edge; returns at the rising edge of the transfer.
    task automatic send_item(input t_in it);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(negedge i_clk);
        while (in_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    // Fields that the operation ignores still carry random values.
    task automatic load_symbol(input int sym, input bit last);
        t_in it;
        it.operation = OP_LOAD;
        it.symbol = sym[SYM_W-1:0];
        it.last = last;
        it.rank = AW'($urandom_range(0, 4095));
        send_item(it);
    endtask

    task automatic read_rank(input int rank);
        t_in it;
        it.operation = OP_READ;
        it.symbol = SYM_W'($urandom_range(0, 127));
        it.last = 1'($urandom_range(0, 1));
        it.rank = rank[AW-1:0];
        send_item(it);
    endtask

    // Loads count valid symbols from [lo, hi], the last one marked last, with
    // an occasional dropped symbol or early read mixed in.
    task automatic load_text(input int count, input int lo, input int hi);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    load_symbol($urandom_range(0, 36), 1'b0);
                end else begin
                    read_rank($urandom_range(0, 4095));
                end
            end
            load_symbol($urandom_range(lo, hi), i == count - 1);
        end
    endtask

    // Reads mostly valid ranks of a text of length n, now and then any rank.
    task automatic read_ranks(input int count, input int n);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                read_rank($urandom_range(0, 4095));
            end else begin
                read_rank($urandom_range(0, n - 1));
            end
        end
    endtask

    initial begin
        int n;
        int texts;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        burst = 1'b0;
        hold_pending = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        items_sent = 0;
        texts = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: a read before any build, symbols at and below the
        // terminator, the extremes of the symbol range, reads over every rank
        // and past the end, a dropped symbol that still starts construction,
        // and a build on an empty text right after a finished one.
        read_rank(0);
        load_symbol(0, 1'b0);
        load_symbol(36, 1'b0);
        load_symbol(37, 1'b0);
        load_symbol(127, 1'b0);
        load_symbol(100, 1'b1);
        for (int r = 0; r < 4; r++) begin
            read_rank(r);
        end
        read_rank(4);
        read_rank(4095);
        load_symbol(50, 1'b0);
        load_symbol(36, 1'b1);
        read_rank(0);
        read_rank(1);
        load_symbol(5, 1'b1);
        read_rank(0);
        read_rank(1);
        load_symbol(127, 1'b1);
        read_rank(0);
        read_rank(1);

        // Random texts: mostly short, some over a tiny alphabet so that
        // many doubling rounds are needed, a few longer ones.
        while (items_sent < 1450) begin
            burst = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(31, 200);
            end else begin
                n = $urandom_range(1, 30);
            end
            if (texts == 5) begin
                hold_pending = 1'b1;
            end
            case ($urandom_range(0, 2))
                0: load_text(n, 37, 38);
                1: load_text(n, 37, 40);
                default: load_text(n, 37, 127);
            endcase
            read_ranks($urandom_range(3, 12), n + 1);
            texts++;
        end

        in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);

        $display("Sent %0d items: directed corner cases and %0d random texts,",
                 items_sent, texts);
        $display("checked %0d results over %0d suffix array builds.", checked, builds);
        if (errors == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Generous bound on the whole run, even when every text is long and needs the most
    // doubling rounds.
    initial begin
        #100ms;
        $display("Timeout with %0d results still expected", pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sabb_pkg.sv
rtl/sabb_ram.sv
rtl/sabb_ctrl.sv
rtl/sabb_dpath.sv
rtl/suffix_array_bwt_builder.sv
sim/suffix_array_checker.sv
sim/suffix_array_bwt_builder_tb.sv
